// File: sv/spl_pkg.sv
package spl_pkg;

	// Payload widths of the channels
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned TAG_W   = 16;
	localparam int unsigned PRIO_W  = 2;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned COUNT_W = 5;

	// Default list sizes
	localparam int unsigned PENDING_DEPTH_DEF = 16;
	localparam int unsigned LOG_DEPTH_DEF     = 16;

	// Depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Command kinds as they arrive on the input channel
	localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RD_PEND  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RD_LOG   = 2'd3;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_COMPLETE,
		OP_RD_PEND,
		OP_RD_LOG
	} op_code_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_BADPOS  = 3'd3,
		ST_LOGFULL = 3'd4
	} status_t;

	// One stored list entry
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Classified command handed from front to back
	typedef struct packed {
		op_code_t          code;
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
		logic              pos_zero;
		logic [POS_W-1:0]  idx;
	} op_t;

endpackage

// File: sv/spl_if.sv
// Command channel
interface spl_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [spl_pkg::KIND_W-1:0]    kind;
	logic [spl_pkg::TAG_W-1:0]     tag;
	logic [spl_pkg::PRIO_W-1:0]    priority_req;
	logic [spl_pkg::POS_W-1:0]     position;

	modport source (output valid, kind, tag, priority_req, position, input ready);
	modport sink   (input valid, kind, tag, priority_req, position, output ready);
endinterface

// Response channel
interface spl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [spl_pkg::STAT_W-1:0]    status;
	logic [spl_pkg::TAG_W-1:0]     out_tag;
	logic [spl_pkg::PRIO_W-1:0]    out_priority;
	logic [spl_pkg::COUNT_W-1:0]   pending_count;
	logic [spl_pkg::COUNT_W-1:0]   completed_count;

	modport source (output valid, status, out_tag, out_priority, pending_count,
		completed_count, input ready);
	modport sink   (input valid, status, out_tag, out_priority, pending_count,
		completed_count, output ready);
endinterface

// File: sv/stable_priority_list_with_log_top.sv
// A rejected command or an add to an empty list is answered from idle; a read goes
// through its read state; an add walks down the list and moves each lower-priority
// entry up one slot; a complete reads the entry, closes the gap over the entries that
// follow and logs it if the log has room. One command is in the list sequencer at
// a time, and a new one is taken only in idle with the response register free.
// Reset clears counts, control and handshake state only; stored entries are not cleared.
module stable_priority_list_with_log_top #(
	parameter int unsigned PENDING_DEPTH = spl_pkg::PENDING_DEPTH_DEF,
	parameter int unsigned LOG_DEPTH     = spl_pkg::LOG_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	spl_cmd_if.sink    cmd,
	spl_rsp_if.source  rsp
);

	logic         op_valid;
	logic         op_ready;
	spl_pkg::op_t op;

	// Front: accept and classify words, buffer them
	spl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	// Back: list sequencer with its memories and response register
	spl_back #(
		.PENDING_DEPTH (PENDING_DEPTH),
		.LOG_DEPTH     (LOG_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op),
		.rsp      (rsp)
	);

	// Back only starts a command when the response register can take its result
	a_start_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready |-> !rsp.valid || rsp.ready)
		else $error("command started while response register blocked");

	// A full log shows in the completed count
	a_logfull_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == spl_pkg::ST_LOGFULL
		|-> rsp.completed_count == spl_pkg::COUNT_W'(LOG_DEPTH))
		else $error("log full reported with log not full");

	// Nothing pending means a pending count of zero
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == spl_pkg::ST_EMPTY |-> rsp.pending_count == '0)
		else $error("empty reported with entries pending");

	// Back-pressure on the command side only when the queue holds work
	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && !cmd.ready |-> op_valid)
		else $error("command stalled with empty queue");

endmodule

// File: sv/spl_front.sv
module spl_front (
	input  logic           clk,
	input  logic           arst_n,
	spl_cmd_if.sink        cmd,
	output logic           op_valid,
	input  logic           op_ready,
	output spl_pkg::op_t   op
);

	localparam int unsigned QPW = $clog2(spl_pkg::QUEUE_DEPTH);
	localparam int unsigned QCW = $clog2(spl_pkg::QUEUE_DEPTH + 1);

	spl_pkg::op_t   queue_q [spl_pkg::QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;
	spl_pkg::op_t   cls;
	logic           push;
	logic           pop;

	// Classify the incoming word
	always_comb begin
		cls.tag      = cmd.tag;
		cls.prio     = cmd.priority_req;
		cls.pos_zero = (cmd.position == '0);
		cls.idx      = cls.pos_zero ? '0 : cmd.position - 1'b1;
		unique case (cmd.kind)
			spl_pkg::KIND_ADD:      cls.code = spl_pkg::OP_ADD;
			spl_pkg::KIND_COMPLETE: cls.code = spl_pkg::OP_COMPLETE;
			spl_pkg::KIND_RD_PEND:  cls.code = spl_pkg::OP_RD_PEND;
			spl_pkg::KIND_RD_LOG:   cls.code = spl_pkg::OP_RD_LOG;
		endcase
	end

	assign cmd.ready = (fill_q != QCW'(spl_pkg::QUEUE_DEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign op_valid  = (fill_q != '0);
	assign pop       = op_valid && op_ready;
	assign op        = queue_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(spl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(spl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/spl_back.sv
module spl_back #(
	parameter int unsigned PENDING_DEPTH = spl_pkg::PENDING_DEPTH_DEF,
	parameter int unsigned LOG_DEPTH     = spl_pkg::LOG_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	output logic           op_ready,
	input  spl_pkg::op_t   op,
	spl_rsp_if.source      rsp
);

	localparam int unsigned IW  = $clog2(PENDING_DEPTH);
	localparam int unsigned CW  = $clog2(PENDING_DEPTH + 1);
	localparam int unsigned LIW = $clog2(LOG_DEPTH);
	localparam int unsigned LCW = $clog2(LOG_DEPTH + 1);
	localparam int unsigned MW  = (CW > LCW) ? CW : LCW;
	localparam int unsigned XW  = ((MW > spl_pkg::POS_W) ? MW : spl_pkg::POS_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_CHK,
		S_ADD_HEAD,
		S_CMP_HEAD,
		S_CMP_SHIFT,
		S_CMP_LOG,
		S_RD_PEND,
		S_RD_LOG
	} state_t;

	// Memories
	spl_pkg::entry_t pend_mem [PENDING_DEPTH];
	spl_pkg::entry_t log_mem  [LOG_DEPTH];
	spl_pkg::entry_t prd_data_q;
	spl_pkg::entry_t lrd_data_q;
	logic            pw_en;
	logic [IW-1:0]   pw_addr;
	spl_pkg::entry_t pw_data;
	logic [IW-1:0]   prd_addr;
	logic            lw_en;
	logic [LIW-1:0]  lw_addr;
	logic [LIW-1:0]  lrd_addr;

	// Control state
	state_t          state_q;
	spl_pkg::op_t    op_q;
	logic [IW-1:0]   ptr_q;
	spl_pkg::entry_t entry_q;
	logic [CW-1:0]   pcnt_q;
	logic [LCW-1:0]  ccnt_q;

	// Response register
	logic                          rsp_valid_q;
	spl_pkg::status_t              rsp_status_q;
	spl_pkg::entry_t               rsp_entry_q;
	logic [spl_pkg::COUNT_W-1:0]   rsp_pcnt_q;
	logic [spl_pkg::COUNT_W-1:0]   rsp_ccnt_q;

	// Helpers
	logic                          out_free;
	logic                          take;
	logic [XW-1:0]                 pcnt_x, pinc_x, pdec_x, ccnt_x, cinc_x;
	logic [XW-1:0]                 idx_x, ptr_x;
	logic                          pend_full, log_full, cmp_bad, rdp_bad, rdl_bad;
	spl_pkg::entry_t               new_in, new_q;
	logic                          res_set;
	spl_pkg::status_t              res_status;
	spl_pkg::entry_t               res_entry;
	logic [spl_pkg::COUNT_W-1:0]   res_p5;
	logic [spl_pkg::COUNT_W-1:0]   res_c5;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign op_ready = (state_q == S_IDLE) && out_free;
	assign take     = op_valid && op_ready;

	assign pcnt_x = XW'(pcnt_q);
	assign pinc_x = pcnt_x + 1'b1;
	assign pdec_x = pcnt_x - 1'b1;
	assign ccnt_x = XW'(ccnt_q);
	assign cinc_x = ccnt_x + 1'b1;
	assign idx_x  = XW'(op.idx);
	assign ptr_x  = XW'(ptr_q);

	assign pend_full = (pcnt_x == XW'(PENDING_DEPTH));
	assign log_full  = (ccnt_x == XW'(LOG_DEPTH));
	assign cmp_bad   = (idx_x >= pcnt_x);
	assign rdp_bad   = op.pos_zero || (idx_x >= pcnt_x);
	assign rdl_bad   = op.pos_zero || (idx_x >= ccnt_x);

	assign new_in = '{tag: op.tag, prio: op.prio};
	assign new_q  = '{tag: op_q.tag, prio: op_q.prio};

	// Memory port control and result selection
	always_comb begin
		pw_en      = 1'b0;
		pw_addr    = ptr_q;
		pw_data    = prd_data_q;
		prd_addr   = ptr_q;
		lw_en      = 1'b0;
		lw_addr    = ccnt_q[LIW-1:0];
		lrd_addr   = idx_x[LIW-1:0];
		res_set    = 1'b0;
		res_status = spl_pkg::ST_OK;
		res_entry  = '0;
		res_p5     = pcnt_x[spl_pkg::COUNT_W-1:0];
		res_c5     = ccnt_x[spl_pkg::COUNT_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (op.code)
						spl_pkg::OP_ADD: begin
							prd_addr = pdec_x[IW-1:0];
							if (pend_full) begin
								res_set    = 1'b1;
								res_status = spl_pkg::ST_FULL;
							end else if (pcnt_q == '0) begin
								pw_en     = 1'b1;
								pw_addr   = '0;
								pw_data   = new_in;
								res_set   = 1'b1;
								res_entry = new_in;
								res_p5    = pinc_x[spl_pkg::COUNT_W-1:0];
							end
						end
						spl_pkg::OP_COMPLETE: begin
							prd_addr = idx_x[IW-1:0];
							if (pcnt_q == '0) begin
								res_set    = 1'b1;
								res_status = spl_pkg::ST_EMPTY;
							end else if (cmp_bad) begin
								res_set    = 1'b1;
								res_status = spl_pkg::ST_BADPOS;
							end
						end
						spl_pkg::OP_RD_PEND: begin
							prd_addr = idx_x[IW-1:0];
							if (rdp_bad) begin
								res_set    = 1'b1;
								res_status = spl_pkg::ST_BADPOS;
							end
						end
						spl_pkg::OP_RD_LOG: begin
							if (rdl_bad) begin
								res_set    = 1'b1;
								res_status = spl_pkg::ST_BADPOS;
							end
						end
					endcase
				end
			end
			S_ADD_CHK: begin
				// Entries of lower priority move up one slot; the new entry goes after the first that is not lower
				pw_en   = 1'b1;
				pw_addr = ptr_q + 1'b1;
				if (prd_data_q.prio < op_q.prio) begin
					pw_data  = prd_data_q;
					prd_addr = ptr_q - 1'b1;
				end else begin
					pw_data   = new_q;
					res_set   = 1'b1;
					res_entry = new_q;
					res_p5    = pinc_x[spl_pkg::COUNT_W-1:0];
				end
			end
			S_ADD_HEAD: begin
				pw_en     = 1'b1;
				pw_addr   = '0;
				pw_data   = new_q;
				res_set   = 1'b1;
				res_entry = new_q;
				res_p5    = pinc_x[spl_pkg::COUNT_W-1:0];
			end
			S_CMP_HEAD: begin
				prd_addr = ptr_q + 1'b1;
			end
			S_CMP_SHIFT: begin
				// Close the gap: move the next entry down one slot
				pw_en    = 1'b1;
				pw_addr  = ptr_q;
				pw_data  = prd_data_q;
				prd_addr = ptr_q + IW'(2);
			end
			S_CMP_LOG: begin
				res_set   = 1'b1;
				res_entry = entry_q;
				res_p5    = pdec_x[spl_pkg::COUNT_W-1:0];
				if (log_full) begin
					res_status = spl_pkg::ST_LOGFULL;
				end else begin
					lw_en  = 1'b1;
					res_c5 = cinc_x[spl_pkg::COUNT_W-1:0];
				end
			end
			S_RD_PEND: begin
				res_set   = 1'b1;
				res_entry = prd_data_q;
			end
			S_RD_LOG: begin
				res_set   = 1'b1;
				res_entry = lrd_data_q;
			end
			default: begin
			end
		endcase
	end

	// Pending list memory
	always_ff @(posedge clk) begin
		if (pw_en) begin
			pend_mem[pw_addr] <= pw_data;
		end
		prd_data_q <= pend_mem[prd_addr];
	end

	// Completed log memory
	always_ff @(posedge clk) begin
		if (lw_en) begin
			log_mem[lw_addr] <= entry_q;
		end
		lrd_data_q <= log_mem[lrd_addr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pcnt_q      <= '0;
			ccnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (res_set) begin
				rsp_valid_q  <= 1'b1;
				rsp_status_q <= res_status;
				rsp_entry_q  <= res_entry;
				rsp_pcnt_q   <= res_p5;
				rsp_ccnt_q   <= res_c5;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						op_q <= op;
						unique case (op.code)
							spl_pkg::OP_ADD: begin
								if (!pend_full) begin
									if (pcnt_q == '0) begin
										pcnt_q <= pinc_x[CW-1:0];
									end else begin
										ptr_q   <= pdec_x[IW-1:0];
										state_q <= S_ADD_CHK;
									end
								end
							end
							spl_pkg::OP_COMPLETE: begin
								if (pcnt_q != '0 && !cmp_bad) begin
									ptr_q   <= idx_x[IW-1:0];
									state_q <= S_CMP_HEAD;
								end
							end
							spl_pkg::OP_RD_PEND: begin
								if (!rdp_bad) begin
									state_q <= S_RD_PEND;
								end
							end
							spl_pkg::OP_RD_LOG: begin
								if (!rdl_bad) begin
									state_q <= S_RD_LOG;
								end
							end
						endcase
					end
				end
				S_ADD_CHK: begin
					if (prd_data_q.prio < op_q.prio) begin
						if (ptr_q == '0) begin
							state_q <= S_ADD_HEAD;
						end else begin
							ptr_q <= ptr_q - 1'b1;
						end
					end else begin
						pcnt_q  <= pinc_x[CW-1:0];
						state_q <= S_IDLE;
					end
				end
				S_ADD_HEAD: begin
					pcnt_q  <= pinc_x[CW-1:0];
					state_q <= S_IDLE;
				end
				S_CMP_HEAD: begin
					entry_q <= prd_data_q;
					if (ptr_x + 1'b1 < pcnt_x) begin
						state_q <= S_CMP_SHIFT;
					end else begin
						state_q <= S_CMP_LOG;
					end
				end
				S_CMP_SHIFT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_x + XW'(2) >= pcnt_x) begin
						state_q <= S_CMP_LOG;
					end
				end
				S_CMP_LOG: begin
					pcnt_q <= pdec_x[CW-1:0];
					if (!log_full) begin
						ccnt_q <= cinc_x[LCW-1:0];
					end
					state_q <= S_IDLE;
				end
				S_RD_PEND, S_RD_LOG: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.out_tag         = rsp_entry_q.tag;
	assign rsp.out_priority    = rsp_entry_q.prio;
	assign rsp.pending_count   = rsp_pcnt_q;
	assign rsp.completed_count = rsp_ccnt_q;

endmodule
